>>> sv/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define DCP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dcp assertion failed");

// Checked on every rising clock edge, reset included.
`define DCP_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("dcp assertion failed");

`endif

>>> sv/dcp_pkg.sv
// Fixed field widths and constants of the distance constraint projection.
package dcp_pkg;
  localparam int unsigned MASS_W  = 32;
  localparam int unsigned REST_W  = 31;
  localparam int unsigned STIFF_W = 17;
  localparam int unsigned STIFF_SH = 16;
  localparam logic [STIFF_W-1:0] STIFF_ONE = 17'h10000;
endpackage

>>> sv/distance_constraint_projection_top.sv
// Distance constraint projection: pipelined fixed-point PBD constraint solver.
//
// Input channel s_axis: one word per constraint carrying both points (A, B),
// their inverse masses, the rest length and the stiffness. Output channel
// m_axis: one word per constraint with the corrected points; tuser is the
// applied flag (clear when both inverse masses are zero, points unchanged).
// Zero separation passes the points through, applied set unless both are zero.
//
// Throughput: one word per cycle while the receiver does not stall m_axis.
// TW = max(COORD_BITS + 1, 31) + 1 is the quotient width (34 at COORD_BITS
// = 32) of the two bit-per-stage dividers (by the length, then by the mass
// sum); the square root is bit-per-stage as well.
//
// The whole pipeline advances together; when the receiver holds tready low
// with a word waiting, every stage holds and s_axis_tready drops, so nothing
// is lost or repeated. Reset clears the valid bits only; the block takes
// words in the first cycle after reset.
module distance_constraint_projection_top #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
  // inv_mass_a, inv_mass_b, rest_len, stiff, zero pad
  input  logic [((6*COORD_BITS+2*dcp_pkg::MASS_W+dcp_pkg::REST_W+dcp_pkg::STIFF_W+7)/8)*8-1:0]
               s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z, zero pad
  output logic [((6*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // applied
  output logic m_axis_tuser
);
  import dcp_pkg::*;
`include "assert_macros.svh"

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned SW   = 2*C + 2;
  localparam int unsigned RW   = C + 4;
  localparam int unsigned KMW  = (C + 1 > REST_W) ? C + 1 : REST_W;
  localparam int unsigned TW   = KMW + 1;
  localparam int unsigned NUMW = KMW + C + 2;
  localparam int unsigned WSW  = MASS_W + 1;
  localparam int unsigned MNW  = TW + MASS_W + 1;
  localparam int unsigned EW   = ((C > TW + 1) ? C : TW + 1) + 1;
  localparam int unsigned OUT_TW = ((6*C + 7)/8)*8;

  localparam int unsigned S_SQ  = 1;
  localparam int unsigned S_SUM = 2;
  localparam int unsigned S_RT0 = 3;
  localparam int unsigned S_RND = S_RT0 + C + 1;
  localparam int unsigned S_K1  = S_RND + 1;
  localparam int unsigned S_K2  = S_K1 + 1;
  localparam int unsigned S_P1  = S_K2 + 1;
  localparam int unsigned S_P2  = S_P1 + 1;
  localparam int unsigned S_TD0 = S_P2 + 1;
  localparam int unsigned S_M1  = S_TD0 + TW;
  localparam int unsigned S_M2  = S_M1 + 1;
  localparam int unsigned S_MD0 = S_M2 + 1;
  localparam int unsigned S_OUT = S_MD0 + TW;
  localparam int unsigned NST   = S_OUT + 1;

  typedef struct packed {
    logic [2:0][C-1:0]        a;
    logic [2:0][C-1:0]        b;
    logic [2:0]               nneg;
    logic [2:0][C:0]          nmag;
    logic [MASS_W-1:0]        w1;
    logic [MASS_W-1:0]        w2;
    logic [WSW-1:0]           wsum;
    logic [REST_W-1:0]        rest;
    logic [STIFF_W-1:0]       stf;
    logic [2:0][SW-1:0]       sq;
    logic [SW-1:0]            s;
    logic [RW-1:0]            srem;
    logic [C:0]               root;
    logic                     kneg;
    logic [KMW-1:0]           dmag;
    logic [KMW-1:0]           kmag;
    logic [2:0][KMW+C:0]      prod;
    logic [2:0][C:0]          trem;
    logic [2:0][TW-1:0]       tq;
    logic [2:0]               tneg;
    logic [2:0][TW+MASS_W-1:0] mp1;
    logic [2:0][TW+MASS_W-1:0] mp2;
    logic [2:0][WSW-1:0]      mr1;
    logic [2:0][WSW-1:0]      mr2;
    logic [2:0][TW-1:0]       mq1;
    logic [2:0][TW-1:0]       mq2;
    logic [2:0][C-1:0]        na;
    logic [2:0][C-1:0]        nb;
    logic                     applied;
  } pl_t;

  pl_t        pl_d [NST];
  pl_t        pl_q [NST];
  logic [NST-1:0] v_q;
  logic       en;

  assign en = !v_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;

  // input unpack, stiffness clamp, mass sum, separation vector
  always_comb begin
    logic signed [C:0] n;
    logic [WSW-1:0] ws;
    pl_d[0] = '0;
    for (int i = 0; i < 3; i++) begin
      pl_d[0].a[i] = s_axis_tdata[i*C +: C];
      pl_d[0].b[i] = s_axis_tdata[3*C + i*C +: C];
      n = $signed({pl_d[0].b[i][C-1], pl_d[0].b[i]}) -
          $signed({pl_d[0].a[i][C-1], pl_d[0].a[i]});
      pl_d[0].nneg[i] = n[C];
      pl_d[0].nmag[i] = n[C] ? (C+1)'(-n) : (C+1)'(n);
    end
    pl_d[0].w1   = s_axis_tdata[6*C +: MASS_W];
    pl_d[0].w2   = s_axis_tdata[6*C + MASS_W +: MASS_W];
    pl_d[0].rest = s_axis_tdata[6*C + 2*MASS_W +: REST_W];
    pl_d[0].stf  = s_axis_tdata[6*C + 2*MASS_W + REST_W +: STIFF_W];
    if (pl_d[0].stf > STIFF_ONE) begin
      pl_d[0].stf = STIFF_ONE;
    end
    ws = {1'b0, pl_d[0].w1} + {1'b0, pl_d[0].w2};
    pl_d[0].wsum = ws;
  end

  for (genvar g = 1; g < NST; g++) begin : g_st
    if (g == S_SQ) begin : g_sq
      always_comb begin
        logic [SW-1:0] m;
        pl_d[g] = pl_q[g-1];
        for (int i = 0; i < 3; i++) begin
          m = {{(C+1){1'b0}}, pl_q[g-1].nmag[i]};
          pl_d[g].sq[i] = m * m;
        end
      end
    end else if (g == S_SUM) begin : g_sum
      always_comb begin
        pl_d[g] = pl_q[g-1];
        pl_d[g].s = pl_q[g-1].sq[0] + pl_q[g-1].sq[1] + pl_q[g-1].sq[2];
        pl_d[g].srem = '0;
        pl_d[g].root = '0;
      end
    end else if (g >= S_RT0 && g < S_RND) begin : g_rt
      // one root bit per stage, two radicand bits consumed
      localparam int unsigned P = C - (g - S_RT0);
      always_comb begin
        logic [RW-1:0] r2;
        logic [RW-1:0] trial;
        pl_d[g] = pl_q[g-1];
        r2    = {pl_q[g-1].srem[C+1:0], pl_q[g-1].s[2*P+1 -: 2]};
        trial = {1'b0, pl_q[g-1].root, 2'b01};
        if (r2 >= trial) begin
          pl_d[g].srem = r2 - trial;
          pl_d[g].root = {pl_q[g-1].root[C-1:0], 1'b1};
        end else begin
          pl_d[g].srem = r2;
          pl_d[g].root = {pl_q[g-1].root[C-1:0], 1'b0};
        end
      end
    end else if (g == S_RND) begin : g_rnd
      always_comb begin
        pl_d[g] = pl_q[g-1];
        if (pl_q[g-1].srem > {3'b000, pl_q[g-1].root}) begin
          pl_d[g].root = pl_q[g-1].root + 1'b1;
        end
      end
    end else if (g == S_K1) begin : g_k1
      always_comb begin
        logic signed [KMW:0] dif;
        pl_d[g] = pl_q[g-1];
        dif = $signed((KMW+1)'(pl_q[g-1].root)) - $signed((KMW+1)'(pl_q[g-1].rest));
        pl_d[g].kneg = dif[KMW];
        pl_d[g].dmag = dif[KMW] ? KMW'(-dif) : KMW'(dif);
      end
    end else if (g == S_K2) begin : g_k2
      always_comb begin
        logic [KMW+STIFF_W:0] kp;
        pl_d[g] = pl_q[g-1];
        kp = (KMW+STIFF_W+1)'(pl_q[g-1].dmag) * (KMW+STIFF_W+1)'(pl_q[g-1].stf)
           + ((KMW+STIFF_W+1)'(1) << (STIFF_SH - 1));
        pl_d[g].kmag = kp[STIFF_SH +: KMW];
      end
    end else if (g == S_P1) begin : g_p1
      always_comb begin
        logic [KMW+C:0] ka;
        pl_d[g] = pl_q[g-1];
        ka = (KMW+C+1)'(pl_q[g-1].kmag);
        for (int i = 0; i < 3; i++) begin
          pl_d[g].prod[i] = ka * (KMW+C+1)'(pl_q[g-1].nmag[i]);
        end
      end
    end else if (g == S_P2) begin : g_p2
      always_comb begin
        logic [NUMW-1:0] num;
        pl_d[g] = pl_q[g-1];
        for (int i = 0; i < 3; i++) begin
          num = {1'b0, pl_q[g-1].prod[i]} + NUMW'(pl_q[g-1].root >> 1);
          pl_d[g].trem[i] = num[NUMW-1:TW];
          pl_d[g].tq[i]   = num[TW-1:0];
          pl_d[g].tneg[i] = pl_q[g-1].kneg ^ pl_q[g-1].nneg[i];
        end
      end
    end else if (g >= S_TD0 && g < S_M1) begin : g_td
      // restoring division by the length, one quotient bit per stage
      always_comb begin
        logic [C+1:0] r2;
        logic         ge;
        pl_d[g] = pl_q[g-1];
        for (int i = 0; i < 3; i++) begin
          r2 = {pl_q[g-1].trem[i], pl_q[g-1].tq[i][TW-1]};
          ge = r2 >= {1'b0, pl_q[g-1].root};
          pl_d[g].trem[i] = ge ? (C+1)'(r2 - {1'b0, pl_q[g-1].root}) : r2[C:0];
          pl_d[g].tq[i]   = {pl_q[g-1].tq[i][TW-2:0], ge};
        end
      end
    end else if (g == S_M1) begin : g_m1
      always_comb begin
        logic [TW+MASS_W-1:0] t;
        pl_d[g] = pl_q[g-1];
        for (int i = 0; i < 3; i++) begin
          t = (TW+MASS_W)'(pl_q[g-1].tq[i]);
          pl_d[g].mp1[i] = t * (TW+MASS_W)'(pl_q[g-1].w1);
          pl_d[g].mp2[i] = t * (TW+MASS_W)'(pl_q[g-1].w2);
        end
      end
    end else if (g == S_M2) begin : g_m2
      always_comb begin
        logic [MNW-1:0] m1;
        logic [MNW-1:0] m2;
        logic [MNW-1:0] hf;
        pl_d[g] = pl_q[g-1];
        hf = MNW'(pl_q[g-1].wsum >> 1);
        for (int i = 0; i < 3; i++) begin
          m1 = {1'b0, pl_q[g-1].mp1[i]} + hf;
          m2 = {1'b0, pl_q[g-1].mp2[i]} + hf;
          pl_d[g].mr1[i] = m1[MNW-1:TW];
          pl_d[g].mq1[i] = m1[TW-1:0];
          pl_d[g].mr2[i] = m2[MNW-1:TW];
          pl_d[g].mq2[i] = m2[TW-1:0];
        end
      end
    end else if (g >= S_MD0 && g < S_OUT) begin : g_md
      // restoring division by the mass sum, both points side by side
      always_comb begin
        logic [WSW:0] r1;
        logic [WSW:0] r2;
        logic [WSW:0] dv;
        logic         ge1;
        logic         ge2;
        pl_d[g] = pl_q[g-1];
        dv = {1'b0, pl_q[g-1].wsum};
        for (int i = 0; i < 3; i++) begin
          r1  = {pl_q[g-1].mr1[i], pl_q[g-1].mq1[i][TW-1]};
          r2  = {pl_q[g-1].mr2[i], pl_q[g-1].mq2[i][TW-1]};
          ge1 = r1 >= dv;
          ge2 = r2 >= dv;
          pl_d[g].mr1[i] = ge1 ? WSW'(r1 - dv) : r1[WSW-1:0];
          pl_d[g].mr2[i] = ge2 ? WSW'(r2 - dv) : r2[WSW-1:0];
          pl_d[g].mq1[i] = {pl_q[g-1].mq1[i][TW-2:0], ge1};
          pl_d[g].mq2[i] = {pl_q[g-1].mq2[i][TW-2:0], ge2};
        end
      end
    end else begin : g_out
      // apply moves, saturate to the coordinate range
      always_comb begin
        logic signed [TW:0]   da;
        logic signed [TW:0]   db;
        logic signed [EW-1:0] sa;
        logic signed [EW-1:0] sb;
        logic                 mv;
        pl_d[g] = pl_q[g-1];
        pl_d[g].applied = pl_q[g-1].wsum != '0;
        mv = pl_d[g].applied && (pl_q[g-1].root != '0);
        for (int i = 0; i < 3; i++) begin
          da = $signed({1'b0, pl_q[g-1].mq1[i]});
          db = $signed({1'b0, pl_q[g-1].mq2[i]});
          if (pl_q[g-1].tneg[i]) begin
            da = -da;
          end else begin
            db = -db;
          end
          if (!mv) begin
            da = '0;
            db = '0;
          end
          sa = EW'($signed(pl_q[g-1].a[i])) + EW'(da);
          sb = EW'($signed(pl_q[g-1].b[i])) + EW'(db);
          if ((&sa[EW-1:C-1]) || !(|sa[EW-1:C-1])) begin
            pl_d[g].na[i] = sa[C-1:0];
          end else begin
            pl_d[g].na[i] = sa[EW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
          end
          if ((&sb[EW-1:C-1]) || !(|sb[EW-1:C-1])) begin
            pl_d[g].nb[i] = sb[C-1:0];
          end else begin
            pl_d[g].nb[i] = sb[EW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        pl_q[i] <= pl_d[i];
      end
    end
  end

  assign m_axis_tvalid = v_q[NST-1];
  assign m_axis_tdata  = OUT_TW'({pl_q[NST-1].nb, pl_q[NST-1].na});
  assign m_axis_tuser  = pl_q[NST-1].applied;

  `DCP_ASSERT(a_enter, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> v_q[0])
  `DCP_ASSERT(a_hold, clk_i, rst_ni, !en |=> $stable(v_q))
  `DCP_ASSERT_ALL(a_rst, clk_i, !rst_ni |-> ##1 !m_axis_tvalid || !$past(rst_ni) == 1'b0)

endmodule
